### rtl/rueg_pkg.sv
// ----------------------------------------------------------------------------
// Random unique edge generator package
// Shared constants, datapath command codes and the control/status structs.
// ----------------------------------------------------------------------------
package rueg_pkg;

	localparam int MAX_NODES = 64;
	localparam int MAX_TRIES = 4096;
	localparam int MT_N      = 624;
	localparam int MT_M      = 397;

	localparam int NODE_W = $clog2(MAX_NODES);
	localparam int CNT_W  = $clog2(MAX_NODES + 1);
	localparam int TRY_W  = $clog2(MAX_TRIES + 1);
	localparam int IDX_W  = $clog2(MT_N);
	localparam int EDGE_W = 12;
	localparam int STAT_W = 3;
	localparam int WORD_W = 32;
	localparam int CFGI_W = 2;
	localparam int OP_W   = 5;

	localparam logic [WORD_W-1:0] MT_MULT = 32'd1812433253;
	localparam logic [WORD_W-1:0] MT_MAG  = 32'h9908b0df;

	localparam logic [CNT_W-1:0]  NODE_COUNT_RST   = CNT_W'(64);
	localparam logic [WORD_W-1:0] MAX_DISTANCE_RST = 32'd65536;
	localparam logic [WORD_W-1:0] SEED_VALUE_RST   = 32'd5489;

	localparam logic [CFGI_W-1:0] CFG_NODE_COUNT   = 2'd0;
	localparam logic [CFGI_W-1:0] CFG_MAX_DISTANCE = 2'd1;
	localparam logic [CFGI_W-1:0] CFG_SEED_VALUE   = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
	localparam logic [STAT_W-1:0] ST_TOO_MANY  = 3'd1;
	localparam logic [STAT_W-1:0] ST_BAD_SEED  = 3'd2;
	localparam logic [STAT_W-1:0] ST_DONE      = 3'd3;
	localparam logic [STAT_W-1:0] ST_EXHAUSTED = 3'd4;

	localparam logic OPER_START = 1'b0;

	localparam logic [OP_W-1:0] DP_NOP       = 5'd0;
	localparam logic [OP_W-1:0] DP_CAPTURE   = 5'd1;
	localparam logic [OP_W-1:0] DP_SEED_INIT = 5'd2;
	localparam logic [OP_W-1:0] DP_SEED_WR   = 5'd3;
	localparam logic [OP_W-1:0] DP_SEED_ADD  = 5'd4;
	localparam logic [OP_W-1:0] DP_SET_EDGES = 5'd5;
	localparam logic [OP_W-1:0] DP_KILL      = 5'd6;
	localparam logic [OP_W-1:0] DP_TRY_INIT  = 5'd7;
	localparam logic [OP_W-1:0] DP_TRY       = 5'd8;
	localparam logic [OP_W-1:0] DP_RD0       = 5'd9;
	localparam logic [OP_W-1:0] DP_RD1       = 5'd10;
	localparam logic [OP_W-1:0] DP_RDM       = 5'd11;
	localparam logic [OP_W-1:0] DP_TW        = 5'd12;
	localparam logic [OP_W-1:0] DP_MODI_FROM = 5'd13;
	localparam logic [OP_W-1:0] DP_MODI_TO   = 5'd14;
	localparam logic [OP_W-1:0] DP_MOD_STEP  = 5'd15;
	localparam logic [OP_W-1:0] DP_SET_FROM  = 5'd16;
	localparam logic [OP_W-1:0] DP_SET_TO    = 5'd17;
	localparam logic [OP_W-1:0] DP_BM_RD     = 5'd18;
	localparam logic [OP_W-1:0] DP_BM_WR     = 5'd19;
	localparam logic [OP_W-1:0] DP_MUL       = 5'd20;
	localparam logic [OP_W-1:0] DP_DIV1      = 5'd21;
	localparam logic [OP_W-1:0] DP_DIV2      = 5'd22;
	localparam logic [OP_W-1:0] DP_OUT       = 5'd23;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [STAT_W-1:0] st;
	} cmd_t;

	typedef struct packed {
		logic op_next;
		logic too_many;
		logic seed_zero;
		logic edges_zero;
		logic tries_max;
		logic seed_last;
		logic mod_last;
		logic rem_last;
		logic pair_used;
		logic out_free;
	} stat_t;

	function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] v);
		logic [WORD_W-1:0] y;
		y = v;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & 32'h9d2c5680);
		y = y ^ ((y << 15) & 32'hefc60000);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage

### rtl/random_unique_edge_generator.sv
// ----------------------------------------------------------------------------
// Random unique edge generator
// Emits random undirected edges without repeats from a seeded MT19937.
// ----------------------------------------------------------------------------
//   channel  | direction | contents
//   s_axis   | in        | tuser: operation; tdata: edge_count
//   m_axis   | out       | tuser: status; tdata: from_node, to_node, distance
//   cfg      | in        | cfg_index, cfg_data, always ready
//
// A start item seeds the 624 generator words through the shared 32x32 multiplier,
// with a multiply state and an add state per word, and the 64 bitmap rows are
// cleared alongside. The pair draws of a next item are paced by the single read
// port of the twister memory and by the 4-bit-per-cycle remainder unit.
// One item is worked at a time; a finished result waits in the output register
// while the next item is accepted. Reset returns the configuration to defaults.
// ----------------------------------------------------------------------------
module random_unique_edge_generator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // edge_count[11:0], zero fill
	input  logic [0:0]  s_axis_tuser,  // operation[0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // from_node[5:0], to_node[11:6], distance[43:12]
	output logic [2:0]  m_axis_tuser,  // status[2:0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	rueg_pkg::cmd_t  cmd;
	rueg_pkg::stat_t stat;
	logic [rueg_pkg::NODE_W-1:0] out_from, out_to;
	logic [rueg_pkg::WORD_W-1:0] out_distance;

	assign cfg_ready = 1'b1;

	rueg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rueg_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.in_operation  (s_axis_tuser[0]),
		.in_edge_count (s_axis_tdata[rueg_pkg::EDGE_W-1:0]),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_idx       (cfg_index),
		.cfg_wdata     (cfg_data),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.out_status    (m_axis_tuser),
		.out_from      (out_from),
		.out_to        (out_to),
		.out_distance  (out_distance)
	);

	assign m_axis_tdata = {4'b0000, out_distance, out_to, out_from};

endmodule

### rtl/rueg_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rueg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/rueg_ctrl.sv
// ----------------------------------------------------------------------------
// Edge generator controller
// Sequences seeding, generator draws, remainders, bitmap checks and results.
// ----------------------------------------------------------------------------
module rueg_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rueg_pkg::stat_t     stat,
	output rueg_pkg::cmd_t      cmd
);

	localparam logic [4:0] S_IDLE      = 5'd0;
	localparam logic [4:0] S_DECIDE    = 5'd1;
	localparam logic [4:0] S_SEED_WR   = 5'd2;
	localparam logic [4:0] S_SEED_ADD  = 5'd3;
	localparam logic [4:0] S_SEED_DONE = 5'd4;
	localparam logic [4:0] S_TRY       = 5'd5;
	localparam logic [4:0] S_RD0       = 5'd6;
	localparam logic [4:0] S_RD1       = 5'd7;
	localparam logic [4:0] S_RDM       = 5'd8;
	localparam logic [4:0] S_TW        = 5'd9;
	localparam logic [4:0] S_MODI      = 5'd10;
	localparam logic [4:0] S_MOD       = 5'd11;
	localparam logic [4:0] S_SET_FROM  = 5'd12;
	localparam logic [4:0] S_SET_TO    = 5'd13;
	localparam logic [4:0] S_BM_RD     = 5'd14;
	localparam logic [4:0] S_BM_CHK    = 5'd15;
	localparam logic [4:0] S_MUL       = 5'd16;
	localparam logic [4:0] S_DIV1      = 5'd17;
	localparam logic [4:0] S_DIV2      = 5'd18;
	localparam logic [4:0] S_OUT       = 5'd19;

	localparam logic [1:0] PU_FROM = 2'd0;
	localparam logic [1:0] PU_TO   = 2'd1;
	localparam logic [1:0] PU_DIST = 2'd2;

	logic [4:0]                  state_q, state_d;
	logic [1:0]                  pu_q, pu_d;
	logic [rueg_pkg::STAT_W-1:0] st_q, st_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pu_q    <= PU_FROM;
			st_q    <= rueg_pkg::ST_OK;
		end else begin
			state_q <= state_d;
			pu_q    <= pu_d;
			st_q    <= st_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		pu_d     = pu_q;
		st_d     = st_q;
		cmd.op   = rueg_pkg::DP_NOP;
		cmd.st   = st_q;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = rueg_pkg::DP_CAPTURE;
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (!stat.op_next) begin
					if (stat.too_many) begin
						cmd.op  = rueg_pkg::DP_KILL;
						st_d    = rueg_pkg::ST_TOO_MANY;
						state_d = S_OUT;
					end else if (stat.seed_zero) begin
						cmd.op  = rueg_pkg::DP_KILL;
						st_d    = rueg_pkg::ST_BAD_SEED;
						state_d = S_OUT;
					end else begin
						cmd.op  = rueg_pkg::DP_SEED_INIT;
						state_d = S_SEED_WR;
					end
				end else if (stat.edges_zero) begin
					st_d    = rueg_pkg::ST_DONE;
					state_d = S_OUT;
				end else begin
					cmd.op  = rueg_pkg::DP_TRY_INIT;
					state_d = S_TRY;
				end
			end
			S_SEED_WR: begin
				cmd.op  = rueg_pkg::DP_SEED_WR;
				state_d = stat.seed_last ? S_SEED_DONE : S_SEED_ADD;
			end
			S_SEED_ADD: begin
				cmd.op  = rueg_pkg::DP_SEED_ADD;
				state_d = S_SEED_WR;
			end
			S_SEED_DONE: begin
				cmd.op  = rueg_pkg::DP_SET_EDGES;
				st_d    = rueg_pkg::ST_OK;
				state_d = S_OUT;
			end
			S_TRY: begin
				if (stat.tries_max) begin
					cmd.op  = rueg_pkg::DP_KILL;
					st_d    = rueg_pkg::ST_EXHAUSTED;
					state_d = S_OUT;
				end else begin
					cmd.op  = rueg_pkg::DP_TRY;
					pu_d    = PU_FROM;
					state_d = S_RD0;
				end
			end
			S_RD0: begin
				cmd.op  = rueg_pkg::DP_RD0;
				state_d = S_RD1;
			end
			S_RD1: begin
				cmd.op  = rueg_pkg::DP_RD1;
				state_d = S_RDM;
			end
			S_RDM: begin
				cmd.op  = rueg_pkg::DP_RDM;
				state_d = S_TW;
			end
			S_TW: begin
				cmd.op  = rueg_pkg::DP_TW;
				state_d = (pu_q == PU_DIST) ? S_MUL : S_MODI;
			end
			S_MODI: begin
				cmd.op  = (pu_q == PU_FROM) ? rueg_pkg::DP_MODI_FROM : rueg_pkg::DP_MODI_TO;
				state_d = S_MOD;
			end
			S_MOD: begin
				cmd.op = rueg_pkg::DP_MOD_STEP;
				if (stat.mod_last) begin
					state_d = (pu_q == PU_FROM) ? S_SET_FROM : S_SET_TO;
				end
			end
			S_SET_FROM: begin
				cmd.op = rueg_pkg::DP_SET_FROM;
				if (stat.rem_last) begin
					state_d = S_BM_RD;
				end else begin
					pu_d    = PU_TO;
					state_d = S_RD0;
				end
			end
			S_SET_TO: begin
				cmd.op  = rueg_pkg::DP_SET_TO;
				state_d = S_BM_RD;
			end
			S_BM_RD: begin
				cmd.op  = rueg_pkg::DP_BM_RD;
				state_d = S_BM_CHK;
			end
			S_BM_CHK: begin
				if (stat.pair_used) begin
					state_d = S_TRY;
				end else begin
					cmd.op  = rueg_pkg::DP_BM_WR;
					pu_d    = PU_DIST;
					state_d = S_RD0;
				end
			end
			S_MUL: begin
				cmd.op  = rueg_pkg::DP_MUL;
				state_d = S_DIV1;
			end
			S_DIV1: begin
				cmd.op  = rueg_pkg::DP_DIV1;
				state_d = S_DIV2;
			end
			S_DIV2: begin
				cmd.op  = rueg_pkg::DP_DIV2;
				st_d    = rueg_pkg::ST_OK;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (stat.out_free) begin
					cmd.op  = rueg_pkg::DP_OUT;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

### rtl/rueg_dp.sv
// ----------------------------------------------------------------------------
// Edge generator datapath
// Configuration, generator words, pair bitmap, remainder unit and result register.
// ----------------------------------------------------------------------------
module rueg_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rueg_pkg::cmd_t                cmd,
	output rueg_pkg::stat_t               stat,
	input  logic                          in_operation,
	input  logic [rueg_pkg::EDGE_W-1:0]   in_edge_count,
	input  logic                          cfg_we,
	input  logic [rueg_pkg::CFGI_W-1:0]   cfg_idx,
	input  logic [rueg_pkg::WORD_W-1:0]   cfg_wdata,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [rueg_pkg::STAT_W-1:0]   out_status,
	output logic [rueg_pkg::NODE_W-1:0]   out_from,
	output logic [rueg_pkg::NODE_W-1:0]   out_to,
	output logic [rueg_pkg::WORD_W-1:0]   out_distance
);

	localparam int NW = rueg_pkg::NODE_W;
	localparam int CW = rueg_pkg::CNT_W;
	localparam int IW = rueg_pkg::IDX_W;
	localparam int WW = rueg_pkg::WORD_W;
	localparam int MN = rueg_pkg::MAX_NODES;

	logic [CW-1:0]                 node_count_q;
	logic [WW-1:0]                 max_distance_q;
	logic [WW-1:0]                 seed_value_q;
	logic                          op_q;
	logic [rueg_pkg::EDGE_W-1:0]   want_q;
	logic [rueg_pkg::EDGE_W-1:0]   edges_q;
	logic [rueg_pkg::TRY_W-1:0]    tries_q;
	logic [IW-1:0]                 idx_q;
	logic [IW-1:0]                 k_q;
	logic [WW-1:0]                 p_q;
	logic [2*WW-1:0]               prod_q;
	logic [WW:0]                   sum_q;
	logic [WW-1:0]                 w0_q, w1_q, r_q;
	logic [WW-1:0]                 dvd_q;
	logic [NW-1:0]                 rem_q, dvs_q;
	logic [2:0]                    mcnt_q;
	logic [NW-1:0]                 from_q, to_q;
	logic [WW-1:0]                 dist_q;

	logic [CW-1:0]                 n_use;
	logic [2*CW-1:0]               n_sq;
	logic [IW-1:0]                 idx_nx, idx_m;
	logic                          tw_we, tw_re;
	logic [IW-1:0]                 tw_waddr, tw_raddr;
	logic [WW-1:0]                 tw_wdata, tw_rdata;
	logic [WW-1:0]                 y_tw, v_tw;
	logic                          bm_we, bm_re;
	logic [NW-1:0]                 bm_waddr;
	logic [MN-1:0]                 bm_wdata, bm_rdata;
	logic [WW-1:0]                 mul_a, mul_b;
	logic [NW-1:0]                 rem_nx;
	logic [WW-1:0]                 dvd_nx;
	logic [1:0]                    corr;

	always_comb begin
		if (node_count_q < CW'(3)) begin
			n_use = CW'(3);
		end else if (node_count_q > CW'(MN)) begin
			n_use = CW'(MN);
		end else begin
			n_use = node_count_q;
		end
	end

	assign n_sq   = {{CW{1'b0}}, n_use} * {{CW{1'b0}}, n_use};
	assign idx_nx = (idx_q == IW'(rueg_pkg::MT_N - 1)) ? '0 : IW'(idx_q + IW'(1));
	assign idx_m  = (idx_q >= IW'(rueg_pkg::MT_N - rueg_pkg::MT_M)) ?
		IW'(idx_q - IW'(rueg_pkg::MT_N - rueg_pkg::MT_M)) : IW'(idx_q + IW'(rueg_pkg::MT_M));

	assign y_tw = {w0_q[WW-1], w1_q[WW-2:0]};
	assign v_tw = tw_rdata ^ (y_tw >> 1) ^ (y_tw[0] ? rueg_pkg::MT_MAG : '0);

	always_comb begin
		tw_we    = 1'b0;
		tw_waddr = idx_q;
		tw_wdata = v_tw;
		tw_re    = 1'b0;
		tw_raddr = idx_q;
		case (cmd.op)
			rueg_pkg::DP_SEED_WR: begin
				tw_we    = 1'b1;
				tw_waddr = k_q;
				tw_wdata = p_q;
			end
			rueg_pkg::DP_RD0: begin
				tw_re = 1'b1;
			end
			rueg_pkg::DP_RD1: begin
				tw_re    = 1'b1;
				tw_raddr = idx_nx;
			end
			rueg_pkg::DP_RDM: begin
				tw_re    = 1'b1;
				tw_raddr = idx_m;
			end
			rueg_pkg::DP_TW: begin
				tw_we = 1'b1;
			end
			default: begin
				tw_we = 1'b0;
			end
		endcase
	end

	always_comb begin
		bm_we    = 1'b0;
		bm_waddr = from_q;
		bm_wdata = bm_rdata | (MN'(1) << to_q);
		bm_re    = (cmd.op == rueg_pkg::DP_BM_RD);
		if (cmd.op == rueg_pkg::DP_SEED_WR && k_q < IW'(MN)) begin
			bm_we    = 1'b1;
			bm_waddr = k_q[NW-1:0];
			bm_wdata = '0;
		end else if (cmd.op == rueg_pkg::DP_BM_WR) begin
			bm_we = 1'b1;
		end
	end

	rueg_ram #(.WIDTH(WW), .DEPTH(rueg_pkg::MT_N)) u_tw_ram (
		.clk   (clk),
		.we    (tw_we),
		.waddr (tw_waddr),
		.wdata (tw_wdata),
		.re    (tw_re),
		.raddr (tw_raddr),
		.rdata (tw_rdata)
	);

	rueg_ram #(.WIDTH(MN), .DEPTH(MN)) u_bm_ram (
		.clk   (clk),
		.we    (bm_we),
		.waddr (bm_waddr),
		.wdata (bm_wdata),
		.re    (bm_re),
		.raddr (from_q),
		.rdata (bm_rdata)
	);

	always_comb begin
		logic [NW:0] t;
		logic [NW-1:0] r;
		logic [WW-1:0] d;
		r = rem_q;
		d = dvd_q;
		for (int b = 0; b < 4; b++) begin
			t = {r, d[WW-1]};
			d = d << 1;
			if (t >= {1'b0, dvs_q}) begin
				t = t - {1'b0, dvs_q};
			end
			r = t[NW-1:0];
		end
		rem_nx = r;
		dvd_nx = d;
	end

	assign mul_a = (cmd.op == rueg_pkg::DP_MUL) ? r_q : (p_q ^ (p_q >> 30));
	assign mul_b = (cmd.op == rueg_pkg::DP_MUL) ? max_distance_q : rueg_pkg::MT_MULT;

	always_comb begin
		if (sum_q >= {1'b1, 32'hffff_fffe}) begin
			corr = 2'd2;
		end else if (sum_q >= {1'b0, 32'hffff_ffff}) begin
			corr = 2'd1;
		end else begin
			corr = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q   <= rueg_pkg::NODE_COUNT_RST;
			max_distance_q <= rueg_pkg::MAX_DISTANCE_RST;
			seed_value_q   <= rueg_pkg::SEED_VALUE_RST;
			edges_q        <= '0;
			idx_q          <= '0;
			out_valid      <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					rueg_pkg::CFG_NODE_COUNT:   node_count_q   <= cfg_wdata[CW-1:0];
					rueg_pkg::CFG_MAX_DISTANCE: max_distance_q <= cfg_wdata;
					rueg_pkg::CFG_SEED_VALUE:   seed_value_q   <= cfg_wdata;
					default: begin
					end
				endcase
			end
			case (cmd.op)
				rueg_pkg::DP_SEED_INIT: idx_q   <= '0;
				rueg_pkg::DP_SET_EDGES: edges_q <= want_q;
				rueg_pkg::DP_KILL:      edges_q <= '0;
				rueg_pkg::DP_TW:        idx_q   <= idx_nx;
				rueg_pkg::DP_DIV2:      edges_q <= edges_q - rueg_pkg::EDGE_W'(1);
				default: begin
				end
			endcase
			if (cmd.op == rueg_pkg::DP_OUT) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			rueg_pkg::DP_CAPTURE: begin
				op_q   <= in_operation;
				want_q <= in_edge_count;
			end
			rueg_pkg::DP_SEED_INIT: begin
				k_q <= '0;
				p_q <= seed_value_q;
			end
			rueg_pkg::DP_SEED_WR: begin
				prod_q <= {{WW{1'b0}}, mul_a} * {{WW{1'b0}}, mul_b};
				k_q    <= IW'(k_q + IW'(1));
			end
			rueg_pkg::DP_SEED_ADD: begin
				p_q <= prod_q[WW-1:0] + WW'(k_q);
			end
			rueg_pkg::DP_TRY_INIT: begin
				tries_q <= '0;
			end
			rueg_pkg::DP_TRY: begin
				tries_q <= tries_q + rueg_pkg::TRY_W'(1);
			end
			rueg_pkg::DP_RD1: begin
				w0_q <= tw_rdata;
			end
			rueg_pkg::DP_RDM: begin
				w1_q <= tw_rdata;
			end
			rueg_pkg::DP_TW: begin
				r_q <= rueg_pkg::temper(v_tw);
			end
			rueg_pkg::DP_MODI_FROM: begin
				dvd_q  <= r_q;
				rem_q  <= '0;
				mcnt_q <= '0;
				dvs_q  <= NW'(n_use - CW'(1));
			end
			rueg_pkg::DP_MODI_TO: begin
				dvd_q  <= r_q;
				rem_q  <= '0;
				mcnt_q <= '0;
				dvs_q  <= NW'(n_use - {1'b0, from_q} - CW'(2));
			end
			rueg_pkg::DP_MOD_STEP: begin
				dvd_q  <= dvd_nx;
				rem_q  <= rem_nx;
				mcnt_q <= mcnt_q + 3'd1;
			end
			rueg_pkg::DP_SET_FROM: begin
				from_q <= rem_q;
				to_q   <= NW'(n_use - CW'(1));
			end
			rueg_pkg::DP_SET_TO: begin
				to_q <= NW'(rem_q + from_q + NW'(1));
			end
			rueg_pkg::DP_MUL: begin
				prod_q <= {{WW{1'b0}}, mul_a} * {{WW{1'b0}}, mul_b};
			end
			rueg_pkg::DP_DIV1: begin
				sum_q <= {1'b0, prod_q[2*WW-1:WW]} + {1'b0, prod_q[WW-1:0]};
			end
			rueg_pkg::DP_DIV2: begin
				dist_q <= prod_q[2*WW-1:WW] + WW'(corr);
			end
			rueg_pkg::DP_OUT: begin
				out_status <= cmd.st;
				if (cmd.st == rueg_pkg::ST_OK && op_q != rueg_pkg::OPER_START) begin
					out_from     <= from_q;
					out_to       <= to_q;
					out_distance <= dist_q;
				end else begin
					out_from     <= '0;
					out_to       <= '0;
					out_distance <= '0;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		stat.op_next    = (op_q != rueg_pkg::OPER_START);
		stat.too_many   = ({2'b00, want_q} >= {1'b0, n_sq[2*CW-1:1]});
		stat.seed_zero  = (seed_value_q == '0);
		stat.edges_zero = (edges_q == '0);
		stat.tries_max  = (tries_q >= rueg_pkg::TRY_W'(rueg_pkg::MAX_TRIES));
		stat.seed_last  = (k_q == IW'(rueg_pkg::MT_N - 1));
		stat.mod_last   = (mcnt_q == 3'd7);
		stat.rem_last   = ({1'b0, rem_q} == CW'(n_use - CW'(2)));
		stat.pair_used  = bm_rdata[to_q];
		stat.out_free   = !out_valid || out_ready;
	end

endmodule

### rtl/rueg_checker.sv
// ----------------------------------------------------------------------------
// Edge generator port checker
// Checks result content and transfer ordering seen on the top-level ports.
// ----------------------------------------------------------------------------
module rueg_port_checks (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [47:0] m_axis_tdata,
	input logic [2:0]  m_axis_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=>
		(m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
		else $error("result changed while stalled");

	a_no_edge_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser != rueg_pkg::ST_OK) |-> (m_axis_tdata == '0))
		else $error("non-edge result carries edge data");

	a_edge_order: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == rueg_pkg::ST_OK && m_axis_tdata != '0) |->
		(m_axis_tdata[5:0] < m_axis_tdata[11:6]))
		else $error("edge endpoints out of order");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input taken while an item is in work");

endmodule

bind random_unique_edge_generator rueg_port_checks u_rueg_port_checks (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
